// File: hdl/tccw_pkg.sv
package tccw_pkg;

   localparam logic [7:0] NL_CODE    = 8'h0A;
   localparam logic [7:0] CR_CODE    = 8'h0D;
   localparam logic [7:0] SPACE_CODE = 8'h20;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic CSR_FG_COLOR = 1'b0;
   localparam logic CSR_BG_COLOR = 1'b1;

   localparam logic [3:0] FG_COLOR_RESET = 4'd0;
   localparam logic [3:0] BG_COLOR_RESET = 4'd2;

   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] char_code;
   } cell_type;

endpackage

// File: hdl/text_console_char_writer.sv
// A put is taken when idle; unless it scrolls, its result strobes in the next cycle;
// a read goes through the store read port register, then ST_READ strobes the result.
// A put that scrolls holds busy while the store copies rows up one cell a cycle
// (reading and writing through its separate ports) and then fills the last row.
// After reset a clearing pass writes zero to all COLUMNS*ROWS cells, one a cycle,
// with busy high. The receiver cannot stall results.
module text_console_char_writer
   import tccw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_strobe,
   output logic [10:0] rsp_cursor_position,
   output logic [7:0]  rsp_read_char,
   output logic [7:0]  rsp_read_attr,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CLW   = $clog2(COLUMNS + 1);

   localparam logic [AW-1:0]  LAST_A   = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0]  CELLS_M1 = AW'(CELLS - 1);
   localparam logic [AW-1:0]  COL_A    = AW'(COLUMNS);
   localparam logic [CLW-1:0] COLS_M1  = CLW'(COLUMNS - 1);
   localparam logic [AW+10:0] CELLS_X  = (AW + 11)'(CELLS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_COPY  = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;

   cell_type mem [CELLS];

   logic [2:0]     state_ff, state_in;
   logic [AW-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]  cursor_ff, cursor_in;
   logic [CLW-1:0] col_ff, col_in;
   logic [3:0]     fg_ff, bg_ff;
   logic           strobe_ff, strobe_in;
   logic [7:0]     rchar_ff, rchar_in;
   logic [7:0]     rattr_ff, rattr_in;
   logic           oob_ff, oob_in;
   cell_type       rd_data_ff;

   logic           we;
   logic [AW-1:0]  wa;
   cell_type       wd;
   logic [AW-1:0]  ra;
   logic           accept;
   logic [AW+10:0] idx_ext;
   logic [AW+10:0] cur_ext;
   logic [AW+CLW-1:0] col_ext;
   logic [AW-1:0]  row_start;
   cell_type       new_cell;
   cell_type       fill_cell;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign idx_ext   = {{AW{1'b0}}, req_cell_index};
   assign cur_ext   = {11'd0, cursor_ff};
   assign col_ext   = {{AW{1'b0}}, col_ff};
   assign row_start = cursor_ff - col_ext[AW-1:0];
   assign new_cell  = '{attr: {fg_ff, bg_ff}, char_code: req_char_code};
   assign fill_cell = '{attr: {fg_ff, bg_ff}, char_code: SPACE_CODE};

   assign rsp_strobe          = strobe_ff;
   assign rsp_cursor_position = cur_ext[10:0];
   assign rsp_read_char       = rchar_ff;
   assign rsp_read_attr       = rattr_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cursor_in = cursor_ff;
      col_in    = col_ff;
      strobe_in = 1'b0;
      rchar_in  = rchar_ff;
      rattr_in  = rattr_ff;
      oob_in    = oob_ff;
      we        = 1'b0;
      wa        = cnt_ff;
      wd        = '0;
      ra        = idx_ext[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            if (cnt_ff == CELLS_M1) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_READ) begin
                  oob_in   = !(idx_ext < CELLS_X);
                  state_in = ST_READ;
               end else begin
                  rchar_in = 8'd0;
                  rattr_in = 8'd0;
                  if (req_char_code == NL_CODE) begin
                     if (row_start >= LAST_A) begin
                        state_in = ST_COPY;
                     end else begin
                        cursor_in = row_start + COL_A;
                        col_in    = '0;
                        strobe_in = 1'b1;
                     end
                  end else if (req_char_code == CR_CODE) begin
                     cursor_in = row_start;
                     col_in    = '0;
                     strobe_in = 1'b1;
                  end else begin
                     we = 1'b1;
                     wa = cursor_ff;
                     wd = new_cell;
                     if (cursor_ff == CELLS_M1) begin
                        state_in = ST_COPY;
                     end else begin
                        cursor_in = cursor_ff + 1'b1;
                        col_in    = (col_ff == COLS_M1) ? '0 : col_ff + 1'b1;
                        strobe_in = 1'b1;
                     end
                  end
                  if (state_in == ST_COPY) begin
                     cursor_in = LAST_A;
                     col_in    = '0;
                     cnt_in    = '0;
                  end
               end
            end
         end
         ST_READ: begin
            strobe_in = 1'b1;
            rchar_in  = oob_ff ? 8'd0 : rd_data_ff.char_code;
            rattr_in  = oob_ff ? 8'd0 : rd_data_ff.attr;
            state_in  = ST_IDLE;
         end
         ST_COPY: begin
            ra = cnt_ff + COL_A;
            if (cnt_ff != '0) begin
               we = 1'b1;
               wa = cnt_ff - 1'b1;
               wd = rd_data_ff;
            end
            if (cnt_ff == LAST_A) begin
               state_in = ST_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FILL: begin
            we = 1'b1;
            wd = fill_cell;
            if (cnt_ff == CELLS_M1) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      rchar_ff <= rchar_in;
      rattr_ff <= rattr_in;
      oob_ff   <= oob_in;
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cnt_ff    <= '0;
         cursor_ff <= '0;
         col_ff    <= '0;
         strobe_ff <= 1'b0;
         fg_ff     <= FG_COLOR_RESET;
         bg_ff     <= BG_COLOR_RESET;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FG_COLOR) begin
               fg_ff <= csr_wdata;
            end else begin
               bg_ff <= csr_wdata;
            end
         end
      end
   end

endmodule
